// ===== rtl/frame_rms_level_dbov_unit_assert.svh =====
// assertion macros for the frame rms level meter
`ifndef FRAME_RMS_LEVEL_DBOV_UNIT_ASSERT_SVH
`define FRAME_RMS_LEVEL_DBOV_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FRL_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("frame rms level check failed");

// next-cycle implication, disabled while in reset
`define FRL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("frame rms level check failed");

`endif

// ===== rtl/frlvl_pkg.sv =====
// package for the frame rms level meter: constants, codes and state type
`timescale 1ns / 1ps
`default_nettype none

package frlvl_pkg;

    localparam int MAX_FRAME_SAMPLES = 4096;
    localparam int LEVEL_FRAC_BITS   = 8;
    localparam int ROUND_SHIFT       = 32 - LEVEL_FRAC_BITS;

    localparam int SUM_W   = 60;
    localparam int COUNT_W = 13;
    localparam int LEVEL_W = 17;
    localparam int LOG_W   = 22;

    localparam int OUT_MAX = 65535;
    localparam int OUT_MIN = -65536;

    localparam int SILENCE_INT = -(127 * (1 << LEVEL_FRAC_BITS));
    localparam logic signed [LEVEL_W-1:0] SILENCE_Q =
        LEVEL_W'((SILENCE_INT < OUT_MIN) ? OUT_MIN : SILENCE_INT);

    // 10*log10(2) in Q16
    localparam logic [17:0] TEN_LOG10_2_Q16 = 18'd197283;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_SAMPLES);

    // sample format codes
    localparam logic [2:0] FMT_S16 = 3'd0;
    localparam logic [2:0] FMT_S32 = 3'd1;
    localparam logic [2:0] FMT_F32 = 3'd2;
    localparam logic [2:0] FMT_S24 = 3'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SQ,
        ST_ACC,
        ST_FIN,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_MULT,
        ST_ROUND,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/frame_rms_level_dbov_unit.sv =====
// frame rms level meter: sample squaring, accumulation and iterative dBov log
//
// Input words come on the s_ channel: s_tdata carries the raw sample bits,
// s_tuser the format code and a sample flag, s_tlast closes the frame.
// A word with the flag low adds nothing; marked last it still closes.
// One result word per closed frame leaves on the m_ channel: m_tdata holds
// the level in dBov (signed, 8 fraction bits), m_tuser the silence flag.
// A sample word is latched, converted, squared in the one shared multiplier
// and added; s_tready is high only while the sequencer idles. A word that
// adds nothing skips the square and the add. Closing a frame runs two
// logarithms of 6 normalize steps and 16 squaring steps each, then a
// difference, a scale multiply and rounding. A silent frame skips both logs.
// The result sits in an output register; if the receiver stalls, the block
// still takes and accumulates the next frame, and waits only when that
// frame closes while the previous result has not been taken.
// Reset clears the sum, the count, the format flag and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module frame_rms_level_dbov_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // sample_word[31:0]
    input  wire logic [3:0]  s_tuser,   // sample_format[2:0], sample_valid[3]
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // level_db_q8[16:0], zero fill
    output logic [0:0]       m_tuser    // silent_code[0]
);

    import frlvl_pkg::*;

    state_t state_reg, state_next;

    logic [31:0]        word_reg, word_next;
    logic [2:0]         fmt_reg, fmt_next;
    logic               sval_reg, sval_next;
    logic               last_reg, last_next;
    logic [31:0]        a_reg, a_next;
    logic [63:0]        sq_reg, sq_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bad_reg, bad_next;
    logic [63:0]        x_reg, x_next;
    logic [5:0]         e_reg, e_next;
    logic [2:0]         step_reg, step_next;
    logic [30:0]        m_reg, m_next;
    logic [15:0]        frac_reg, frac_next;
    logic [3:0]         it_reg, it_next;
    logic               phase_reg, phase_next;
    logic [LOG_W-1:0]   lsum_reg, lsum_next;
    logic [LOG_W-1:0]   lcnt_reg, lcnt_next;
    logic signed [23:0] d_reg, d_next;
    logic signed [43:0] p_reg, p_next;
    logic [LEVEL_W-1:0] res_lvl_reg, res_lvl_next;
    logic               res_sil_reg, res_sil_next;
    logic               mvalid_reg, mvalid_next;
    logic [LEVEL_W-1:0] out_lvl_reg, out_lvl_next;
    logic               out_sil_reg, out_sil_next;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;

    // conversion, normalize and log step helpers
    logic signed [32:0] v_calc;
    logic [31:0]        a_calc;
    logic [31:0]        fmag;
    logic [31:0]        ffull;
    logic [7:0]         fexp;
    logic [7:0]         rsh;
    logic               fsat;
    logic               fneg;
    logic               top_zero;
    logic [5:0]         shamt;
    logic [63:0]        x_shift;
    logic [31:0]        mq;
    logic signed [43:0] r_calc;
    logic               silent;
    logic               out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {7'd0, out_lvl_reg};
    assign m_tuser  = out_sil_reg;
    assign out_free = !mvalid_reg || m_tready;
    assign silent   = bad_reg || (count_reg == '0) || (sum_reg == '0);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ:
            begin
                mul_a = $signed({2'b00, a_reg});
                mul_b = $signed({2'b00, a_reg});
            end
            ST_LOG:
            begin
                mul_a = $signed({3'b000, m_reg});
                mul_b = $signed({3'b000, m_reg});
            end
            ST_MULT:
            begin
                mul_a = 34'(d_reg);
                mul_b = $signed({16'd0, TEN_LOG10_2_Q16});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // float32 to q8.24 magnitude
    always_comb
    begin
        fexp  = word_reg[30:23];
        fneg  = word_reg[31];
        ffull = {8'd0, 1'b1, word_reg[22:0]};
        rsh   = 8'd126 - fexp;
        fsat  = 1'b0;
        fmag  = '0;
        if (fexp == 8'd255 && word_reg[22:0] != '0)
        begin
            fmag = '0;
        end
        else if (fexp == 8'd0)
        begin
            fmag = '0;
        end
        else if (fexp >= 8'd134)
        begin
            fsat = 1'b1;
        end
        else if (fexp >= 8'd126)
        begin
            fmag = ffull << (fexp[2:0] - 3'd6);
        end
        else if (rsh < 8'd32)
        begin
            fmag = ffull >> rsh[4:0];
        end
        else
        begin
            fmag = '0;
        end
    end

    // normalize a sample to q8.24 and take its magnitude
    always_comb
    begin
        v_calc = '0;
        a_calc = '0;
        unique case (fmt_reg)
            FMT_S16: v_calc = 33'($signed(word_reg[15:0])) <<< 9;
            FMT_S32: v_calc = 33'($signed(word_reg)) >>> 7;
            FMT_S24: v_calc = 33'($signed(word_reg[23:0])) <<< 1;
            default: v_calc = '0;
        endcase
        if (fmt_reg == FMT_F32)
        begin
            if (fsat)
            begin
                a_calc = fneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                a_calc = fmag;
            end
        end
        else
        begin
            a_calc = v_calc[32] ? 32'(-v_calc) : v_calc[31:0];
        end
    end

    // one binary step of the leading-one search
    always_comb
    begin
        top_zero = 1'b0;
        shamt    = 6'd0;
        unique case (step_reg)
            3'd0:
            begin
                shamt    = 6'd32;
                top_zero = (x_reg[63:32] == '0);
            end
            3'd1:
            begin
                shamt    = 6'd16;
                top_zero = (x_reg[63:48] == '0);
            end
            3'd2:
            begin
                shamt    = 6'd8;
                top_zero = (x_reg[63:56] == '0);
            end
            3'd3:
            begin
                shamt    = 6'd4;
                top_zero = (x_reg[63:60] == '0);
            end
            3'd4:
            begin
                shamt    = 6'd2;
                top_zero = (x_reg[63:62] == '0);
            end
            3'd5:
            begin
                shamt    = 6'd1;
                top_zero = !x_reg[63];
            end
            default:
            begin
                shamt    = 6'd0;
                top_zero = 1'b0;
            end
        endcase
        x_shift = top_zero ? (x_reg << shamt) : x_reg;
    end

    assign mq     = prod[61:30];
    assign r_calc = (p_reg + $signed(44'(64'd1 << (ROUND_SHIFT - 1)))) >>> ROUND_SHIFT;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        word_next    = word_reg;
        fmt_next     = fmt_reg;
        sval_next    = sval_reg;
        last_next    = last_reg;
        a_next       = a_reg;
        sq_next      = sq_reg;
        sum_next     = sum_reg;
        count_next   = count_reg;
        bad_next     = bad_reg;
        x_next       = x_reg;
        e_next       = e_reg;
        step_next    = step_reg;
        m_next       = m_reg;
        frac_next    = frac_reg;
        it_next      = it_reg;
        phase_next   = phase_reg;
        lsum_next    = lsum_reg;
        lcnt_next    = lcnt_reg;
        d_next       = d_reg;
        p_next       = p_reg;
        res_lvl_next = res_lvl_reg;
        res_sil_next = res_sil_reg;
        mvalid_next  = mvalid_reg;
        out_lvl_next = out_lvl_reg;
        out_sil_next = out_sil_reg;

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    word_next  = s_tdata;
                    fmt_next   = s_tuser[2:0];
                    sval_next  = s_tuser[3];
                    last_next  = s_tlast;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                a_next = a_calc;
                if (sval_reg && fmt_reg > FMT_S24)
                begin
                    bad_next = 1'b1;
                end
                if (sval_reg && fmt_reg <= FMT_S24 && count_reg < MAX_COUNT)
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                end
            end
            ST_SQ:
            begin
                sq_next    = prod[63:0];
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                sum_next   = sum_reg + SUM_W'(sq_reg[63:16]);
                count_next = count_reg + 1'b1;
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (silent)
                begin
                    res_lvl_next = SILENCE_Q;
                    res_sil_next = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    x_next     = {4'd0, sum_reg};
                    e_next     = 6'd63;
                    step_next  = 3'd0;
                    phase_next = 1'b0;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                x_next    = x_shift;
                e_next    = top_zero ? (e_reg - shamt) : e_reg;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd5)
                begin
                    m_next     = x_shift[63:33];
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (mq[31])
                begin
                    m_next    = mq[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = mq[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == 4'd15)
                begin
                    if (!phase_reg)
                    begin
                        lsum_next  = {e_reg, frac_next};
                        x_next     = {51'd0, count_reg};
                        e_next     = 6'd63;
                        step_next  = 3'd0;
                        phase_next = 1'b1;
                        state_next = ST_NORM;
                    end
                    else
                    begin
                        lcnt_next  = {e_reg, frac_next};
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_DIFF:
            begin
                d_next = $signed({2'b00, lsum_reg}) - $signed({2'b00, lcnt_reg})
                         - 24'sd2097152;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                p_next     = prod[43:0];
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                priority if (r_calc > 44'sd65535)
                begin
                    res_lvl_next = LEVEL_W'(OUT_MAX);
                end
                else if (r_calc < -44'sd65536)
                begin
                    res_lvl_next = LEVEL_W'(OUT_MIN);
                end
                else
                begin
                    res_lvl_next = r_calc[LEVEL_W-1:0];
                end
                res_sil_next = 1'b0;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next  = 1'b1;
                    out_lvl_next = res_lvl_reg;
                    out_sil_next = res_sil_reg;
                    sum_next     = '0;
                    count_next   = '0;
                    bad_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            count_reg   <= '0;
            bad_reg     <= 1'b0;
            mvalid_reg  <= 1'b0;
            out_lvl_reg <= '0;
            out_sil_reg <= 1'b0;
            step_reg    <= '0;
            it_reg      <= '0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            bad_reg     <= bad_next;
            mvalid_reg  <= mvalid_next;
            out_lvl_reg <= out_lvl_next;
            out_sil_reg <= out_sil_next;
            step_reg    <= step_next;
            it_reg      <= it_next;
            phase_reg   <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        fmt_reg     <= fmt_next;
        sval_reg    <= sval_next;
        last_reg    <= last_next;
        a_reg       <= a_next;
        sq_reg      <= sq_next;
        x_reg       <= x_next;
        e_reg       <= e_next;
        m_reg       <= m_next;
        frac_reg    <= frac_next;
        lsum_reg    <= lsum_next;
        lcnt_reg    <= lcnt_next;
        d_reg       <= d_next;
        p_reg       <= p_next;
        res_lvl_reg <= res_lvl_next;
        res_sil_reg <= res_sil_next;
    end

`include "frame_rms_level_dbov_unit_assert.svh"

    // checks
    `FRL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `FRL_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= MAX_COUNT)
    `FRL_ASSERT_IMPLY(a_mant_norm, clk, rst_n, state_reg == ST_LOG, m_reg[30])
    `FRL_ASSERT_IMPLY(a_silence_code, clk, rst_n, m_tvalid && m_tuser[0], out_lvl_reg == SILENCE_Q)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the frame rms level meter: directed table, random frames, self-checking
`timescale 1ns / 1ps

module testbench;
    import frlvl_pkg::*;

    // format codes outside the supported set
    localparam logic [2:0] FMT_UNSUP     = 3'd4;
    localparam logic [2:0] FMT_UNSUP_TOP = 3'd7;
    localparam logic signed [16:0] SIL_LEVEL = -17'sd32512;
    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  fmt;
        logic        smp;
        logic        last;
        logic        typed;
        logic signed [16:0] lvl;
        logic        sil;
    } stim_row_t;

    typedef struct {
        logic signed [16:0] lvl;
        logic               sil;
    } level_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;

    // predictor state
    logic [59:0] acc_sq;
    int          acc_n;
    logic        acc_bad;

    level_t      levels_due[$];
    int          errors;
    int          gap_max;
    int          words_sent;

    frame_rms_level_dbov_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // float32 bits to q8.24, truncated, saturating at +-128
    function automatic longint f32_to_q24(logic [31:0] w);
        int          k;
        logic [63:0] full;
        logic [63:0] mag;
        if (w[30:23] == 8'hFF && w[22:0] != 0)
            return 0;
        if (w[30:23] == 8'h00)
            return 0;
        if (w[30:23] == 8'hFF)
            mag = 64'h8000_0000;
        else
        begin
            k = int'(w[30:23]) - 126;
            full = {40'd0, 1'b1, w[22:0]};
            if (k >= 8)
                mag = 64'h8000_0000;
            else if (k >= 0)
                mag = full << k;
            else if (k > -32)
                mag = full >> (-k);
            else
                mag = 0;
        end
        if (mag >= 64'h8000_0000)
            return w[31] ? -longint'(64'h8000_0000) : longint'(64'h7FFF_FFFF);
        return w[31] ? -longint'(mag) : longint'(mag);
    endfunction

    // log2 as integer part and 16 fraction bits by mantissa squaring
    function automatic logic [63:0] log2_q16(logic [63:0] x);
        int          e;
        logic [63:0] m;
        logic [63:0] frac;
        e = 63;
        frac = 0;
        while (e > 0 && !x[e])
            e--;
        if (e >= 30)
            m = x >> (e - 30);
        else
            m = x << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000)
            begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(e) << 16) | frac;
    endfunction

    // one word into the meter model; returns 1 when a level is produced
    function automatic bit meter_step(logic [31:0] w, logic [2:0] fmt, logic smp,
                                      logic last, output level_t res);
        longint      v;
        logic [63:0] a;
        longint      d;
        longint      lvl;
        logic [63:0] u;
        if (smp)
        begin
            if (fmt > FMT_S24)
                acc_bad = 1'b1;
            else if (acc_n < MAX_FRAME_SAMPLES)
            begin
                case (fmt)
                    FMT_S16: v = longint'($signed(w[15:0])) * 512;
                    FMT_S32: v = longint'($signed(w)) >>> 7;
                    FMT_F32: v = f32_to_q24(w);
                    default: v = longint'($signed(w[23:0])) * 2;
                endcase
                a = (v < 0) ? 64'(-v) : 64'(v);
                acc_sq = acc_sq + 60'((a * a) >> 16);
                acc_n++;
            end
        end
        if (!last)
            return 0;
        res.sil = acc_bad || acc_n == 0 || acc_sq == 0;
        if (res.sil)
            lvl = -(longint'(127) << LEVEL_FRAC_BITS);
        else
        begin
            d = longint'(log2_q16(64'(acc_sq))) - longint'(log2_q16(64'(acc_n)))
                - (longint'(32) << 16);
            u = 64'(d * longint'(TEN_LOG10_2_Q16)) + (64'd1 << 50)
                + (64'd1 << (ROUND_SHIFT - 1));
            lvl = longint'(u >> ROUND_SHIFT) - longint'((64'd1 << 50) >> ROUND_SHIFT);
        end
        if (lvl > OUT_MAX)
            lvl = OUT_MAX;
        if (lvl < OUT_MIN)
            lvl = OUT_MIN;
        res.lvl = 17'(lvl);
        acc_sq = 0;
        acc_n = 0;
        acc_bad = 1'b0;
        return 1;
    endfunction

    // offer one word, wait for acceptance, queue its level if any
    task automatic send_word(input stim_row_t r);
        int     gap;
        level_t res;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= r.word;
        s_tuser  <= {r.smp, r.fmt};
        s_tlast  <= r.last;
        do
            @(negedge clk);
        while (!s_tready);
        if (meter_step(r.word, r.fmt, r.smp, r.last, res))
        begin
            if (r.typed)
            begin
                res.lvl = r.lvl;
                res.sil = r.sil;
            end
            levels_due.push_back(res);
        end
        words_sent++;
        @(posedge clk);
    endtask

    function automatic stim_row_t row(logic [31:0] w, logic [2:0] f, logic s, logic l);
        stim_row_t r;
        r.word = w; r.fmt = f; r.smp = s; r.last = l;
        r.typed = 1'b0; r.lvl = 0; r.sil = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t row_exp(logic [31:0] w, logic [2:0] f, logic s, logic l,
                                          logic signed [16:0] lvl, logic sil);
        stim_row_t r;
        r = row(w, f, s, l);
        r.typed = 1'b1; r.lvl = lvl; r.sil = sil;
        return r;
    endfunction

    // random sample word shaped by format
    function automatic logic [31:0] random_sample(logic [2:0] fmt);
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w = {{24{w[31]}}, w[7:0]};
            1: if (fmt == FMT_F32)
                   w[30:23] = 8'($urandom_range(100, 140));
            default: ;
        endcase
        return w;
    endfunction

    // receiver: random stalls, compare each level word with the oldest prediction
    initial
    begin
        int     stall;
        int     stall_max;
        int     taken;
        level_t want;
        stall_max = 10;
        taken = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(negedge clk);
            while (!m_tvalid);
            if (levels_due.size() == 0)
            begin
                $display("%0t: unexpected level word %0d silent %0d", $time,
                         $signed(m_tdata[16:0]), m_tuser[0]);
                errors++;
            end
            else
            begin
                want = levels_due.pop_front();
                if ($signed(m_tdata[16:0]) !== want.lvl)
                begin
                    $display("%0t: level expected %0d actual %0d", $time, want.lvl,
                             $signed(m_tdata[16:0]));
                    errors++;
                end
                if (m_tuser[0] !== want.sil)
                begin
                    $display("%0t: silent flag expected %0d actual %0d", $time, want.sil,
                             m_tuser[0]);
                    errors++;
                end
            end
            taken++;
            if (taken % 40 == 0)
                stall_max = (stall_max == 0) ? 10 : 0;
            @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        stim_row_t dir[$];
        stim_row_t r;
        int        len;
        logic [2:0] f;
        errors = 0;
        words_sent = 0;
        gap_max = 10;
        acc_sq = 0;
        acc_n = 0;
        acc_bad = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        s_tuser = 4'd0;
        s_tlast = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        dir.push_back(row_exp(32'h0, FMT_S16, 1'b0, 1'b1, SIL_LEVEL, 1'b1));    // empty frame
        dir.push_back(row_exp(32'h8000, FMT_S16, 1'b1, 1'b1, 17'sd0, 1'b0));    // s16 full scale
        dir.push_back(row_exp(32'h0080_0000, FMT_S24, 1'b1, 1'b1, 17'sd0, 1'b0));
        dir.push_back(row_exp(32'h8000_0000, FMT_S32, 1'b1, 1'b1, 17'sd0, 1'b0));
        dir.push_back(row_exp(32'hBF80_0000, FMT_F32, 1'b1, 1'b1, 17'sd0, 1'b0));
        dir.push_back(row(32'h7FFF, FMT_S16, 1'b1, 1'b0));
        dir.push_back(row(32'hFF7F_FFFF, FMT_S24, 1'b1, 1'b0));                 // upper byte ignored
        dir.push_back(row(32'h7FFF_FFFF, FMT_S32, 1'b1, 1'b1));
        dir.push_back(row(32'h4300_0000, FMT_F32, 1'b1, 1'b0));                 // +128 saturates
        dir.push_back(row(32'hFF80_0000, FMT_F32, 1'b1, 1'b0));                 // -inf
        dir.push_back(row(32'h7FC0_0001, FMT_F32, 1'b1, 1'b1));                 // nan counts as zero
        dir.push_back(row_exp(32'h0000_0001, FMT_F32, 1'b1, 1'b1, SIL_LEVEL, 1'b1)); // subnormal
        dir.push_back(row_exp(32'h0000_0001, FMT_S24, 1'b1, 1'b1, SIL_LEVEL, 1'b1)); // square drops
        dir.push_back(row(32'h0000_0100, FMT_S16, 1'b1, 1'b0));
        dir.push_back(row_exp(32'h1234_5678, FMT_UNSUP, 1'b1, 1'b1, SIL_LEVEL, 1'b1));
        dir.push_back(row(32'h0000_7000, FMT_S16, 1'b1, 1'b0));
        dir.push_back(row_exp(32'hFFFF_FFFF, FMT_UNSUP_TOP, 1'b1, 1'b1, SIL_LEVEL, 1'b1));
        dir.push_back(row(32'hFFFF_FFFF, FMT_UNSUP_TOP, 1'b0, 1'b0));           // no sample, ignored
        dir.push_back(row(32'h0000_0001, FMT_S32, 1'b1, 1'b0));
        dir.push_back(row(32'h3F80_0000, FMT_F32, 1'b1, 1'b0));
        dir.push_back(row(32'h0000_0000, FMT_S24, 1'b0, 1'b1));                 // close with no sample
        foreach (dir[i])
            send_word(dir[i]);

        // hold off until every level is back
        s_tvalid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);

        // random frames
        while (words_sent < RANDOM_ITEMS)
        begin
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
            case ($urandom_range(0, 19))
                0: send_word(row($urandom, 3'($urandom), 1'b0, 1'b1));
                1, 2:
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                    begin
                        f = (i == len / 2) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
                        send_word(row(random_sample(f), f, 1'b1, i == len - 1));
                    end
                end
                default:
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 16);
                    for (int i = 0; i < len; i++)
                    begin
                        r.smp = ($urandom_range(0, 9) != 0);
                        f = r.smp ? 3'($urandom_range(0, 3)) : 3'($urandom);
                        send_word(row(random_sample(f), f, r.smp, i == len - 1));
                    end
                end
            endcase
        end
        s_tvalid <= 1'b0;

        // drain
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/frlvl_pkg.sv
rtl/frame_rms_level_dbov_unit.sv
dv/testbench.sv
